@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked through reset
`define CHK_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/p3rts_pkg.sv @@
// Package: constants, types and helper functions of the point transform unit
package p3rts_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int TRIG_BITS       = 16;

  localparam logic [1:0] MODE_ROTATE    = 2'd0;
  localparam logic [1:0] MODE_TRANSLATE = 2'd1;
  localparam logic [1:0] MODE_SCALE     = 2'd2;

  // sine/cosine width (signed) and turn product width
  localparam int TW = TRIG_BITS + 2;
  localparam int PW = 32 + TW;

  // angle reduction: 360 deg = 45 << (frac + 3)
  localparam int     FULL_ODD    = 45;
  localparam int     FSH         = COORD_FRAC_BITS + 3;
  localparam longint FULL_DEG    = longint'(FULL_ODD) << FSH;
  localparam longint QUARTER_DEG = FULL_DEG / 4;
  localparam longint ANG_OFS     = FULL_DEG * ((64'sd2147483648 + FULL_DEG - 1) / FULL_DEG);
  localparam int     ANG_UW      = 35;
  localparam int     ANG_WW      = ANG_UW - FSH;
  localparam int     ANG_RL      = ANG_WW + 1;
  localparam longint RECIP45     = (64'sd1 << ANG_RL) / FULL_ODD;
  localparam int     DW          = COORD_FRAC_BITS + 9;
  localparam int     RW          = COORD_FRAC_BITS + 7;

  localparam longint DEG2RAD_Q32 = 74961321;
  localparam longint ONE_Q30     = 64'sd1 << 30;
  localparam longint TRIG_HALF   = 64'sd1 << (29 - TRIG_BITS);

  // series: q = (v * RECIP) >> RECIP_SH, then one correction step
  localparam int RECIP_SH   = 34;
  localparam int SIN_STEPS  = 7;
  localparam int TAY_STEPS  = 8;
  localparam longint SIN_DIV [SIN_STEPS] = '{6, 20, 42, 72, 110, 156, 210};
  localparam longint COS_DIV [TAY_STEPS] = '{2, 12, 30, 56, 90, 132, 182, 240};
  localparam longint SIN_RECIP [SIN_STEPS] = '{
    (64'sd1 << RECIP_SH) / 6,   (64'sd1 << RECIP_SH) / 20,  (64'sd1 << RECIP_SH) / 42,
    (64'sd1 << RECIP_SH) / 72,  (64'sd1 << RECIP_SH) / 110, (64'sd1 << RECIP_SH) / 156,
    (64'sd1 << RECIP_SH) / 210};
  localparam longint COS_RECIP [TAY_STEPS] = '{
    (64'sd1 << RECIP_SH) / 2,   (64'sd1 << RECIP_SH) / 12,  (64'sd1 << RECIP_SH) / 30,
    (64'sd1 << RECIP_SH) / 56,  (64'sd1 << RECIP_SH) / 90,  (64'sd1 << RECIP_SH) / 132,
    (64'sd1 << RECIP_SH) / 182, (64'sd1 << RECIP_SH) / 240};

  // pipeline stage numbers
  localparam int TAY_ST  = 5;
  localparam int TRIG_ST = TAY_ST + 3 * TAY_STEPS + 1;
  localparam int TURN_ST = TRIG_ST + 1;
  localparam int NSTAGE  = TRIG_ST + 6;

  typedef struct packed {
    logic [2:0][31:0] pt;   // index 0 = x
    logic [2:0]       rot;  // pending turns, index 0 = about x
    logic             ov;
  } carry_t;

  typedef struct packed {
    logic [31:0]        x2;
    logic [1:0]         quad;
    logic [32:0]        ts;
    logic [32:0]        tc;
    logic signed [35:0] ss;
    logic signed [35:0] sc;
  } tay_t;

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
                                                    input int sh);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // {overflow, value}
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  // clamp a Q2.30 sum to [0, 1] and round half up to TRIG_BITS
  function automatic logic [TRIG_BITS:0] trig_round(input logic signed [35:0] s);
    logic [30:0] c;
    logic [30:0] r;
    if (s < 0) begin
      c = '0;
    end else if (s > 36'(ONE_Q30)) begin
      c = 31'(ONE_Q30);
    end else begin
      c = s[30:0];
    end
    r = (c + 31'(TRIG_HALF)) >> (30 - TRIG_BITS);
    return r[TRIG_BITS:0];
  endfunction

endpackage

@@ rtl/p3rts_if.sv @@
// Handshake interfaces of the point transform unit
interface p3rts_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [1:0]         mode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic signed [31:0] operand_c;
  logic               about_x;
  logic               about_y;
  logic               about_z;

  modport source (output valid, point_x, point_y, point_z, mode, operand_a, operand_b,
                  operand_c, about_x, about_y, about_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, mode, operand_a, operand_b,
                operand_c, about_x, about_y, about_z, output ready);
endinterface

interface p3rts_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic signed [31:0] result_z;
  logic               overflow;

  modport source (output valid, result_x, result_y, result_z, overflow, input ready);
  modport sink (input valid, result_x, result_y, result_z, overflow, output ready);
endinterface

@@ rtl/point3d_rotate_translate_scale_unit.sv @@
// Point transform unit: rotate, translate or scale one 3D point per transfer
//
//   port     dir  carries
//   in_pt    in   point, mode, operands, axis flags
//   out_pt   out  transformed point, overflow
//
// One transfer per cycle sustained while the output is not stalled.
// Depth is set by the cosine series: 8 steps of multiply, reciprocal
// multiply and correct, then two stages per axis turn.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes the whole pipe; in_pt.ready drops with it.
module point3d_rotate_translate_scale_unit (
  input  logic        clk,
  input  logic        rst_n,
  p3rts_in_if.sink    in_pt,
  p3rts_out_if.source out_pt
);

  localparam int NS      = p3rts_pkg::NSTAGE;
  localparam int UW      = p3rts_pkg::ANG_UW;
  localparam int WW      = p3rts_pkg::ANG_WW;
  localparam int RL      = p3rts_pkg::ANG_RL;
  localparam int DW      = p3rts_pkg::DW;
  localparam int RW      = p3rts_pkg::RW;
  localparam int TW      = p3rts_pkg::TW;
  localparam int PW      = p3rts_pkg::PW;
  localparam int CFB     = p3rts_pkg::COORD_FRAC_BITS;
  localparam int TB      = p3rts_pkg::TRIG_BITS;
  localparam int TAY_ST  = p3rts_pkg::TAY_ST;
  localparam int TRIG_ST = p3rts_pkg::TRIG_ST;
  localparam int TURN_ST = p3rts_pkg::TURN_ST;
  localparam int NSIN    = p3rts_pkg::SIN_STEPS;
  localparam int NTAY    = p3rts_pkg::TAY_STEPS;
  localparam int RSH     = p3rts_pkg::RECIP_SH;
  localparam longint FULL = p3rts_pkg::FULL_DEG;
  localparam longint QTR  = p3rts_pkg::QUARTER_DEG;

  logic [NS:1] vld_r;
  logic        adv;

  // stage 1
  logic [2:0][31:0]   s1_pt_r;
  logic [1:0]         s1_mode_r;
  logic [2:0]         s1_rot_r;
  logic [2:0][31:0]   s1_tr_r;
  logic [2:0][31:0]   s1_tr_nxt;
  logic               s1_tr_ov_r;
  logic               s1_tr_ov_nxt;
  logic signed [63:0] s1_mul_r [3];
  logic signed [63:0] s1_mul_nxt [3];
  logic [UW-1:0]      s1_u_r;
  logic [UW-1:0]      s1_u_nxt;
  logic [WW-1:0]      s1_qa_r;
  logic [WW-1:0]      s1_qa_nxt;
  logic [WW+RL-1:0]   s1_m45;
  logic signed [31:0] pin [3];
  logic signed [31:0] opd [3];

  // stage 2
  logic [DW-1:0]        s2_d_r;
  logic [DW-1:0]        s2_d_nxt;
  p3rts_pkg::carry_t    car_r [2:NS];
  p3rts_pkg::carry_t    car2_nxt;

  // stages 3 and 4
  logic [1:0]    s3_quad_r;
  logic [1:0]    s3_quad_nxt;
  logic [RW-1:0] s3_rest_r;
  logic [RW-1:0] s3_rest_nxt;
  logic [1:0]    s4_quad_r;
  logic [30:0]   s4_rad_r;
  logic [30:0]   s4_rad_nxt;

  // series
  p3rts_pkg::tay_t tay_r [TAY_ST:TRIG_ST-1];
  p3rts_pkg::tay_t tay5_nxt;
  p3rts_pkg::tay_t tay_c_nxt [NTAY];
  logic [32:0] vs_a_r [NSIN];
  logic [32:0] vs_a_nxt [NSIN];
  logic [32:0] vs_b_r [NSIN];
  logic [32:0] qs_b_r [NSIN];
  logic [32:0] qs_b_nxt [NSIN];
  logic [32:0] vc_a_r [NTAY];
  logic [32:0] vc_a_nxt [NTAY];
  logic [32:0] vc_b_r [NTAY];
  logic [32:0] qc_b_r [NTAY];
  logic [32:0] qc_b_nxt [NTAY];

  // sine/cosine line
  logic signed [TW-1:0] sn_r [TRIG_ST:NS-2];
  logic signed [TW-1:0] cs_r [TRIG_ST:NS-2];
  logic signed [TW-1:0] sn_nxt;
  logic signed [TW-1:0] cs_nxt;

  // turns
  logic signed [PW-1:0] mpc_r [3];
  logic signed [PW-1:0] mqs_r [3];
  logic signed [PW-1:0] mps_r [3];
  logic signed [PW-1:0] mqc_r [3];
  logic signed [PW-1:0] mpc_nxt [3];
  logic signed [PW-1:0] mqs_nxt [3];
  logic signed [PW-1:0] mps_nxt [3];
  logic signed [PW-1:0] mqc_nxt [3];
  p3rts_pkg::carry_t    turn_nxt [3];

  assign adv         = !vld_r[NS] || out_pt.ready;
  assign in_pt.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-1:1], in_pt.valid};
    end
  end

  // ---------------- stage 1: angle quotient, translate, scale products
  always_comb begin
    pin[0] = in_pt.point_x;
    pin[1] = in_pt.point_y;
    pin[2] = in_pt.point_z;
    opd[0] = in_pt.operand_a;
    opd[1] = in_pt.operand_b;
    opd[2] = in_pt.operand_c;
  end

  // offset keeps the angle positive; floor(u / 360deg) by reciprocal, off by at most one
  assign s1_u_nxt  = UW'(opd[0]) + UW'(p3rts_pkg::ANG_OFS);
  assign s1_m45    = (WW+RL)'(s1_u_nxt[UW-1:p3rts_pkg::FSH]) * (WW+RL)'(p3rts_pkg::RECIP45);
  assign s1_qa_nxt = s1_m45[WW+RL-1:RL];

  always_comb begin
    logic [2:0] ov;
    for (int i = 0; i < 3; i++) begin
      {ov[i], s1_tr_nxt[i]} = p3rts_pkg::sat32(64'(pin[i]) + 64'(opd[i]));
      s1_mul_nxt[i]         = 64'(pin[i]) * 64'(opd[i]);
    end
    s1_tr_ov_nxt = |ov;
  end

  // ---------------- stage 2: angle remainder, scale rounding, mode select
  always_comb begin
    logic [UW-1:0]    qfull;
    logic [UW-1:0]    d0;
    logic [2:0]       sov;
    logic [2:0][31:0] sc;
    qfull = UW'(s1_qa_r) * UW'(FULL);
    d0    = s1_u_r - qfull;
    if (d0 >= UW'(FULL)) begin
      s2_d_nxt = DW'(d0 - UW'(FULL));
    end else begin
      s2_d_nxt = DW'(d0);
    end
    for (int i = 0; i < 3; i++) begin
      {sov[i], sc[i]} = p3rts_pkg::sat32(p3rts_pkg::round_away(s1_mul_r[i], CFB));
    end
    car2_nxt.pt  = s1_pt_r;
    car2_nxt.rot = '0;
    car2_nxt.ov  = 1'b0;
    unique case (s1_mode_r)
      p3rts_pkg::MODE_ROTATE: begin
        car2_nxt.rot = s1_rot_r;
      end
      p3rts_pkg::MODE_TRANSLATE: begin
        car2_nxt.pt = s1_tr_r;
        car2_nxt.ov = s1_tr_ov_r;
      end
      p3rts_pkg::MODE_SCALE: begin
        car2_nxt.pt = sc;
        car2_nxt.ov = |sov;
      end
      default: begin
        car2_nxt.pt = s1_pt_r;
      end
    endcase
  end

  // ---------------- stage 3: quadrant split
  always_comb begin
    priority if (s2_d_r >= DW'(3 * QTR)) begin
      s3_quad_nxt = 2'd3;
      s3_rest_nxt = RW'(s2_d_r - DW'(3 * QTR));
    end else if (s2_d_r >= DW'(2 * QTR)) begin
      s3_quad_nxt = 2'd2;
      s3_rest_nxt = RW'(s2_d_r - DW'(2 * QTR));
    end else if (s2_d_r >= DW'(QTR)) begin
      s3_quad_nxt = 2'd1;
      s3_rest_nxt = RW'(s2_d_r - DW'(QTR));
    end else begin
      s3_quad_nxt = 2'd0;
      s3_rest_nxt = RW'(s2_d_r);
    end
  end

  // ---------------- stage 4: degrees to Q2.30 radians
  always_comb begin
    logic [RW+26:0] radp;
    radp       = (RW+27)'(s3_rest_r) * (RW+27)'(p3rts_pkg::DEG2RAD_Q32);
    s4_rad_nxt = radp[CFB+32:CFB+2];
  end

  // ---------------- stage 5: x^2 and series seeds
  always_comb begin
    logic [61:0] x2p;
    x2p           = 62'(s4_rad_r) * 62'(s4_rad_r);
    tay5_nxt.x2   = x2p[61:30];
    tay5_nxt.quad = s4_quad_r;
    tay5_nxt.ts   = 33'(s4_rad_r);
    tay5_nxt.tc   = 33'(p3rts_pkg::ONE_Q30);
    tay5_nxt.ss   = 36'(s4_rad_r);
    tay5_nxt.sc   = 36'(p3rts_pkg::ONE_Q30);
  end

  // ---------------- series steps: term * x^2, reciprocal multiply, correct and add
  always_comb begin
    logic [64:0] pa;
    logic [67:0] pb;
    logic [32:0] rem;
    logic [32:0] t;
    for (int j = 0; j < NTAY; j++) begin
      pa          = 65'(tay_r[TAY_ST+3*j].tc) * 65'(tay_r[TAY_ST+3*j].x2);
      vc_a_nxt[j] = pa[62:30];
      pb          = 68'(vc_a_r[j]) * 68'(p3rts_pkg::COS_RECIP[j]);
      qc_b_nxt[j] = pb[66:34];
      tay_c_nxt[j] = tay_r[TAY_ST+3*j+2];
      rem = vc_b_r[j] - 33'(qc_b_r[j] * 33'(p3rts_pkg::COS_DIV[j]));
      t   = (rem >= 33'(p3rts_pkg::COS_DIV[j])) ? qc_b_r[j] + 33'd1 : qc_b_r[j];
      tay_c_nxt[j].tc = t;
      tay_c_nxt[j].sc = (j % 2 == 0) ? tay_c_nxt[j].sc - $signed(36'(t))
                                     : tay_c_nxt[j].sc + $signed(36'(t));
      if (j < NSIN) begin
        pa          = 65'(tay_r[TAY_ST+3*j].ts) * 65'(tay_r[TAY_ST+3*j].x2);
        vs_a_nxt[j] = pa[62:30];
        pb          = 68'(vs_a_r[j]) * 68'(p3rts_pkg::SIN_RECIP[j]);
        qs_b_nxt[j] = pb[RSH+32:RSH];
        rem = vs_b_r[j] - 33'(qs_b_r[j] * 33'(p3rts_pkg::SIN_DIV[j]));
        t   = (rem >= 33'(p3rts_pkg::SIN_DIV[j])) ? qs_b_r[j] + 33'd1 : qs_b_r[j];
        tay_c_nxt[j].ts = t;
        tay_c_nxt[j].ss = (j % 2 == 0) ? tay_c_nxt[j].ss - $signed(36'(t))
                                       : tay_c_nxt[j].ss + $signed(36'(t));
      end
    end
  end

  // ---------------- trig stage: clamp, round, quadrant map
  always_comb begin
    logic signed [TW-1:0] sv;
    logic signed [TW-1:0] cv;
    sv = TW'($signed({1'b0, p3rts_pkg::trig_round(tay_r[TRIG_ST-1].ss)}));
    cv = TW'($signed({1'b0, p3rts_pkg::trig_round(tay_r[TRIG_ST-1].sc)}));
    unique case (tay_r[TRIG_ST-1].quad)
      2'd0: begin
        sn_nxt = sv;
        cs_nxt = cv;
      end
      2'd1: begin
        sn_nxt = cv;
        cs_nxt = -sv;
      end
      2'd2: begin
        sn_nxt = -sv;
        cs_nxt = -cv;
      end
      default: begin
        sn_nxt = -cv;
        cs_nxt = sv;
      end
    endcase
  end

  // ---------------- turns about x, y, z: products, then round and saturate
  always_comb begin
    logic signed [31:0] p;
    logic signed [31:0] q;
    logic [32:0]        np;
    logic [32:0]        nq;
    for (int k = 0; k < 3; k++) begin
      p = $signed(car_r[TURN_ST+2*k-1].pt[(k+1)%3]);
      q = $signed(car_r[TURN_ST+2*k-1].pt[(k+2)%3]);
      mpc_nxt[k] = PW'(p) * PW'(cs_r[TURN_ST+2*k-1]);
      mqs_nxt[k] = PW'(q) * PW'(sn_r[TURN_ST+2*k-1]);
      mps_nxt[k] = PW'(p) * PW'(sn_r[TURN_ST+2*k-1]);
      mqc_nxt[k] = PW'(q) * PW'(cs_r[TURN_ST+2*k-1]);
      np = p3rts_pkg::sat32(p3rts_pkg::round_away(64'(mpc_r[k]) - 64'(mqs_r[k]), TB));
      nq = p3rts_pkg::sat32(p3rts_pkg::round_away(64'(mps_r[k]) + 64'(mqc_r[k]), TB));
      turn_nxt[k] = car_r[TURN_ST+2*k];
      if (car_r[TURN_ST+2*k].rot[k]) begin
        turn_nxt[k].pt[(k+1)%3] = np[31:0];
        turn_nxt[k].pt[(k+2)%3] = nq[31:0];
        turn_nxt[k].ov          = car_r[TURN_ST+2*k].ov | np[32] | nq[32];
      end
    end
  end

  // ---------------- payload registers, all advance together
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pt_r    <= {in_pt.point_z, in_pt.point_y, in_pt.point_x};
      s1_mode_r  <= in_pt.mode;
      s1_rot_r   <= {in_pt.about_z, in_pt.about_y, in_pt.about_x};
      s1_tr_r    <= s1_tr_nxt;
      s1_tr_ov_r <= s1_tr_ov_nxt;
      s1_mul_r   <= s1_mul_nxt;
      s1_u_r     <= s1_u_nxt;
      s1_qa_r    <= s1_qa_nxt;

      s2_d_r   <= s2_d_nxt;
      car_r[2] <= car2_nxt;
      for (int i = 3; i < TURN_ST; i++) begin
        car_r[i] <= car_r[i-1];
      end

      s3_quad_r <= s3_quad_nxt;
      s3_rest_r <= s3_rest_nxt;
      s4_quad_r <= s3_quad_r;
      s4_rad_r  <= s4_rad_nxt;

      tay_r[TAY_ST] <= tay5_nxt;
      for (int j = 0; j < NTAY; j++) begin
        tay_r[TAY_ST+3*j+1] <= tay_r[TAY_ST+3*j];
        tay_r[TAY_ST+3*j+2] <= tay_r[TAY_ST+3*j+1];
        tay_r[TAY_ST+3*j+3] <= tay_c_nxt[j];
        vc_a_r[j] <= vc_a_nxt[j];
        vc_b_r[j] <= vc_a_r[j];
        qc_b_r[j] <= qc_b_nxt[j];
      end
      for (int j = 0; j < NSIN; j++) begin
        vs_a_r[j] <= vs_a_nxt[j];
        vs_b_r[j] <= vs_a_r[j];
        qs_b_r[j] <= qs_b_nxt[j];
      end

      sn_r[TRIG_ST] <= sn_nxt;
      cs_r[TRIG_ST] <= cs_nxt;
      for (int i = TRIG_ST + 1; i <= NS - 2; i++) begin
        sn_r[i] <= sn_r[i-1];
        cs_r[i] <= cs_r[i-1];
      end

      for (int k = 0; k < 3; k++) begin
        car_r[TURN_ST+2*k]   <= car_r[TURN_ST+2*k-1];
        car_r[TURN_ST+2*k+1] <= turn_nxt[k];
        mpc_r[k] <= mpc_nxt[k];
        mqs_r[k] <= mqs_nxt[k];
        mps_r[k] <= mps_nxt[k];
        mqc_r[k] <= mqc_nxt[k];
      end
    end
  end

  assign out_pt.valid    = vld_r[NS];
  assign out_pt.result_x = $signed(car_r[NS].pt[0]);
  assign out_pt.result_y = $signed(car_r[NS].pt[1]);
  assign out_pt.result_z = $signed(car_r[NS].pt[2]);
  assign out_pt.overflow = car_r[NS].ov;

endmodule

@@ rtl/p3rts_checker.sv @@
// Port-level checker for the point transform unit, bound to the top level
`include "assert_macros.svh"

module p3rts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_x,
  input logic [31:0] result_y,
  input logic [31:0] result_z,
  input logic        overflow
);

  // a waiting result holds until its transfer
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({result_x, result_y, result_z, overflow}), "result changed while stalled")

  // a stalled output blocks the input, a free one never does
  `CHK_NOW(a_backpressure, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")

  // reset empties the pipe
  `CHK_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind point3d_rotate_translate_scale_unit p3rts_checker u_p3rts_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_pt.ready),
  .out_valid(out_pt.valid),
  .out_ready(out_pt.ready),
  .result_x (out_pt.result_x),
  .result_y (out_pt.result_y),
  .result_z (out_pt.result_z),
  .overflow (out_pt.overflow)
);
